>>> rtl/hsif_pkg.sv
// ----------------------------------------------------------------------------
// hsif_pkg
// Shared types, constants and the edge cos/sin generator of the Hough sector
// intercept finder.
// ----------------------------------------------------------------------------
package hsif_pkg;

  // Width of scaled curve values and cell edges
  localparam int SCW = 50;
  // Cap on reported cells per event
  localparam int MAX_RESULTS = 64;
  localparam int NRES_W = 7;

  // Config register indexes
  typedef enum logic [1:0] {
    REG_U_SIDE      = 2'd0,
    REG_HALF_HEIGHT = 2'd1,
    REG_MIN_LINES   = 2'd2
  } reg_index_t;

  // One stored hit: layer code, m, a
  typedef struct packed {
    logic [1:0]         layer;
    logic signed [23:0] m;
    logic signed [23:0] a;
  } hit_entry_t;

  // Per-cell setup handed to the evaluation pipeline
  typedef struct packed {
    logic signed [15:0]     cos_l;
    logic signed [15:0]     sin_l;
    logic signed [15:0]     cos_r;
    logic signed [15:0]     sin_r;
    logic signed [SCW-1:0]  top;
    logic signed [SCW-1:0]  bot;
    logic                   dbl;
  } cell_cfg_t;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  function automatic logic [15:0] q30_to_q15(input longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  // Sin (upper half) and cos (lower half) in Q1.15 of a phase in 2^-16 turn
  function automatic logic [31:0] edge_sincos(input logic [15:0] ph);
    longint unsigned r, x, x2, t3, t5, t7, t9, c2, c4, c6, c8;
    logic [15:0] sv, cv, bs, bc, s, c;
    logic swap;
    r = 64'(ph[13:0]);
    swap = (r > 64'd8192);
    if (swap) r = 64'd16384 - r;
    x  = (r * PI_Q30) >> 15;
    x2 = (x * x) >> 30;
    t3 = ((x * x2) >> 30) / 6;
    t5 = ((t3 * x2) >> 30) / 20;
    t7 = ((t5 * x2) >> 30) / 42;
    t9 = ((t7 * x2) >> 30) / 72;
    c2 = x2 / 2;
    c4 = ((c2 * x2) >> 30) / 12;
    c6 = ((c4 * x2) >> 30) / 30;
    c8 = ((c6 * x2) >> 30) / 56;
    sv = q30_to_q15(x - t3 + t5 - t7 + t9);
    cv = q30_to_q15(ONE_Q30 - c2 + c4 - c6 + c8);
    if (swap) begin
      bs = cv;
      bc = sv;
    end else begin
      bs = sv;
      bc = cv;
    end
    case (ph[15:14])
      2'd0: begin s = bs; c = bc; end
      2'd1: begin s = bc; c = 16'(-bs); end
      2'd2: begin s = 16'(-bs); c = 16'(-bc); end
      default: begin s = 16'(-bc); c = bs; end
    endcase
    return {s, c};
  endfunction

endpackage

>>> rtl/hsif_store.sv
// ----------------------------------------------------------------------------
// hsif_store
// Hit memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hsif_store import hsif_pkg::*; #(
  parameter int MAX_HITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          wr_en,
  input  logic [(MAX_HITS > 1 ? $clog2(MAX_HITS) : 1)-1:0] wr_addr,
  input  hit_entry_t                                    wr_data,
  input  logic                                          rd_en,
  input  logic [(MAX_HITS > 1 ? $clog2(MAX_HITS) : 1)-1:0] rd_addr,
  output hit_entry_t                                    rd_data,
  output logic [(MAX_HITS > 1 ? $clog2(MAX_HITS) : 1)-1:0] rd_index,
  output logic                                          rd_valid
);

  hit_entry_t mem [MAX_HITS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read with index tag
  always_ff @(posedge clk) begin
    rd_data  <= mem[rd_addr];
    rd_index <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= rd_en;
  end

endmodule

>>> rtl/hsif_cell_pipe.sv
// ----------------------------------------------------------------------------
// hsif_cell_pipe
// Crossing test of one hit per cycle against the current cell, with the
// per-cell line count, hit mask and layer set accumulators.
// ----------------------------------------------------------------------------
module hsif_cell_pipe import hsif_pkg::*; #(
  parameter int MAX_HITS     = 32,
  parameter int VERT_SECTORS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  cell_cfg_t                                     cur_cell,
  input  logic                                          clear,
  input  logic                                          in_valid,
  input  hit_entry_t                                    in_hit,
  input  logic [(MAX_HITS > 1 ? $clog2(MAX_HITS) : 1)-1:0] in_index,
  output logic                                          busy,
  output logic [$clog2(MAX_HITS + 1)-1:0]               cnt,
  output logic [31:0]                                   mask,
  output logic [3:0]                                    layers
);

  localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CW = $clog2(MAX_HITS + 1);

  logic signed [39:0] pm_l, pa_l, pm_r, pa_r;
  logic signed [41:0] y_l, y_r;
  logic signed [SCW-1:0] ys_l, ys_r;
  logic gt;
  logic [1:0] lay_a, lay_b, lay_c;
  logic [IW-1:0] idx_a, idx_b, idx_c;
  logic va, vb, vc;
  logic signed [40:0] sum_l, sum_r;
  logic hit;

  // Stage A: four products
  always_ff @(posedge clk) begin
    pm_l  <= in_hit.m * cur_cell.cos_l;
    pa_l  <= in_hit.a * cur_cell.sin_l;
    pm_r  <= in_hit.m * cur_cell.cos_r;
    pa_r  <= in_hit.a * cur_cell.sin_r;
    lay_a <= in_hit.layer;
    idx_a <= in_index;
  end

  // Stage B: sums with side factor
  assign sum_l = 41'(pm_l) + 41'(pa_l);
  assign sum_r = 41'(pm_r) + 41'(pa_r);

  always_ff @(posedge clk) begin
    y_l   <= cur_cell.dbl ? (42'(sum_l) <<< 1) : 42'(sum_l);
    y_r   <= cur_cell.dbl ? (42'(sum_r) <<< 1) : 42'(sum_r);
    lay_b <= lay_a;
    idx_b <= idx_a;
  end

  // Stage C: scale by row count, rising test
  always_ff @(posedge clk) begin
    ys_l  <= SCW'(y_l) * SCW'(VERT_SECTORS);
    ys_r  <= SCW'(y_r) * SCW'(VERT_SECTORS);
    gt    <= (y_r > y_l);
    lay_c <= lay_b;
    idx_c <= idx_b;
  end

  assign hit = (ys_l <= cur_cell.top) && (ys_r >= cur_cell.bot) && gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  // Stage D: accumulate crossing hits
  always_ff @(posedge clk) begin
    if (clear) begin
      cnt    <= '0;
      mask   <= '0;
      layers <= '0;
    end else if (vc && hit) begin
      cnt <= cnt + CW'(1);
      if (int'(idx_c) < 32) mask[5'(idx_c)] <= 1'b1;
      layers[lay_c] <= 1'b1;
    end
  end

  assign busy = in_valid | va | vb | vc;

endmodule

>>> rtl/hough_sector_intercept_finder_top.sv
// ----------------------------------------------------------------------------
// hough_sector_intercept_finder_top
// Loads hits into a memory, then scans the Hough cell grid, one hit test per
// cycle, and streams out candidate cells.
// ----------------------------------------------------------------------------
// Load: one hit beat per cycle, no result.
// Scan: per cell a setup step, one memory read per hit, a drain through the
//   read register and the three test stages, and one count check that can
//   wait on the output, for each of ANGLE_SECTORS*VERT_SECTORS cells; no new
//   hit during it.
// Reset (rst, synchronous): registers to defaults, hit count cleared, idle.
module hough_sector_intercept_finder_top import hsif_pkg::*; #(
  parameter int MAX_HITS      = 32,
  parameter int ANGLE_SECTORS = 8,
  parameter int VERT_SECTORS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // hit_tag[15:0], layer_number[18:16], coef_m[42:19], coef_a[66:43], zero pad
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found[0], angle_index[3:1], row_index[6:4], hit_mask[38:7],
  // line_count[44:39], zero pad
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  localparam int IW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CW  = $clog2(MAX_HITS + 1);
  localparam int CLW = $clog2(ANGLE_SECTORS);
  localparam int TW  = $clog2(ANGLE_SECTORS + 1);
  localparam int RW  = $clog2(VERT_SECTORS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_ISSUE  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_EVAL   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic        u_side;
  logic [22:0] half_height;
  logic [2:0]  min_lines;

  logic [CW-1:0]  stored_count;
  logic [IW-1:0]  rd_ptr;
  logic [CLW-1:0] col;
  logic [RW-1:0]  row;
  logic [NRES_W-1:0] nres;
  cell_cfg_t cur_cell;

  logic        pend_valid;
  logic [2:0]  pend_col, pend_row;
  logic [31:0] pend_mask;
  logic [5:0]  pend_cnt;

  // Edge cos/sin tables for both sides
  logic [31:0] tab_u [ANGLE_SECTORS + 1];
  logic [31:0] tab_v [ANGLE_SECTORS + 1];

  for (genvar j = 0; j <= ANGLE_SECTORS; j++) begin : g_edge
    localparam logic [15:0] PH_U = 16'(((j * 65536) / ANGLE_SECTORS) + 32768);
    localparam logic [15:0] PH_V = 16'(((j * 32768) / ANGLE_SECTORS) + 32768);
    assign tab_u[j] = edge_sincos(PH_U);
    assign tab_v[j] = edge_sincos(PH_V);
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      u_side      <= 1'b1;
      half_height <= 23'd65536;
      min_lines   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_U_SIDE:      u_side      <= cfg_data[0];
        REG_HALF_HEIGHT: half_height <= cfg_data;
        REG_MIN_LINES:   min_lines   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Hit memory and test pipeline
  hit_entry_t wr_hit, rd_hit;
  logic [IW-1:0] rd_index;
  logic rd_valid, accept, store_wr;
  logic pipe_busy;
  logic [CW-1:0] acc_cnt;
  logic [31:0] acc_mask;
  logic [3:0] acc_layers;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign store_wr = accept && (int'(stored_count) < MAX_HITS);
  assign wr_hit.layer = 2'(s_tdata[18:16] + 3'd5);
  assign wr_hit.m     = s_tdata[42:19];
  assign wr_hit.a     = s_tdata[66:43];

  hsif_store #(.MAX_HITS(MAX_HITS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (store_wr),
    .wr_addr  (stored_count[IW-1:0]),
    .wr_data  (wr_hit),
    .rd_en    (state == ST_ISSUE),
    .rd_addr  (rd_ptr),
    .rd_data  (rd_hit),
    .rd_index (rd_index),
    .rd_valid (rd_valid)
  );

  hsif_cell_pipe #(.MAX_HITS(MAX_HITS), .VERT_SECTORS(VERT_SECTORS)) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .cur_cell (cur_cell),
    .clear    (state == ST_SETUP),
    .in_valid (rd_valid),
    .in_hit   (rd_hit),
    .in_index (rd_index),
    .busy     (pipe_busy),
    .cnt      (acc_cnt),
    .mask     (acc_mask),
    .layers   (acc_layers)
  );

  // Cell qualification
  logic [2:0] layer_num;
  logic qual, out_free, last_cell, go, out_load;
  logic signed [7:0]  fac;
  logic signed [31:0] top_prod;
  logic [TW-1:0] ti_l, ti_r;
  logic [31:0] sc_l, sc_r;

  assign layer_num = 3'(acc_layers[0]) + 3'(acc_layers[1]) +
                     3'(acc_layers[2]) + 3'(acc_layers[3]);
  assign qual = (8'(acc_cnt) >= 8'(min_lines)) && (layer_num >= min_lines);
  assign out_free  = !m_tvalid || m_tready;
  assign last_cell = (row == '0) && (int'(col) == ANGLE_SECTORS - 1);
  assign go = !qual || !pend_valid || out_free;
  assign out_load = (state == ST_EVAL && go && qual && pend_valid) ||
                    (state == ST_FINISH && out_free);

  assign fac      = 8'(VERT_SECTORS - 2 * int'(row));
  assign top_prod = $signed({1'b0, half_height}) * fac;
  assign ti_l = TW'(col);
  assign ti_r = TW'(col) + TW'(1);
  assign sc_l = u_side ? tab_u[ti_l] : tab_v[ti_l];
  assign sc_r = u_side ? tab_u[ti_r] : tab_v[ti_r];

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      rd_ptr       <= '0;
      col          <= '0;
      row          <= '0;
      nres         <= '0;
      pend_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_wr) stored_count <= stored_count + CW'(1);
            if (s_tlast) begin
              row        <= RW'(VERT_SECTORS - 1);
              col        <= '0;
              nres       <= '0;
              pend_valid <= 1'b0;
              state      <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          rd_ptr <= '0;
          state  <= ST_ISSUE;
        end
        ST_ISSUE: begin
          rd_ptr <= rd_ptr + IW'(1);
          if (CW'(rd_ptr) + CW'(1) >= stored_count) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!pipe_busy) state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (go) begin
            if (qual) begin
              pend_valid <= 1'b1;
              nres       <= nres + NRES_W'(1);
            end
            if (last_cell || (qual && int'(nres) + 1 == MAX_RESULTS)) begin
              state <= ST_FINISH;
            end else begin
              if (int'(col) == ANGLE_SECTORS - 1) begin
                col <= '0;
                row <= row - RW'(1);
              end else begin
                col <= col + CLW'(1);
              end
              state <= ST_SETUP;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            stored_count <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output valid: raise on load, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  // Cell setup: edge coefficients and row bounds
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      cur_cell.sin_l <= sc_l[31:16];
      cur_cell.cos_l <= sc_l[15:0];
      cur_cell.sin_r <= sc_r[31:16];
      cur_cell.cos_r <= sc_r[15:0];
      cur_cell.top   <= SCW'(top_prod) <<< 15;
      cur_cell.bot   <= (SCW'(top_prod) <<< 15) - (SCW'(half_height) << 16);
      cur_cell.dbl   <= u_side;
    end
  end

  // Pending result and output register payload
  always_ff @(posedge clk) begin
    if (state == ST_EVAL && go && qual) begin
      if (pend_valid) begin
        m_tdata <= {3'b000, pend_cnt, pend_mask, pend_row, pend_col, 1'b1};
        m_tlast <= 1'b0;
      end
      pend_col  <= 3'(col);
      pend_row  <= 3'(row);
      pend_mask <= acc_mask;
      pend_cnt  <= 6'(acc_cnt);
    end else if (state == ST_FINISH && out_free) begin
      if (pend_valid) begin
        m_tdata <= {3'b000, pend_cnt, pend_mask, pend_row, pend_col, 1'b1};
      end else begin
        m_tdata <= '0;
      end
      m_tlast <= 1'b1;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(stored_count) <= MAX_HITS)
    else $error("hit count beyond store size");

  a_drained_setup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> !pipe_busy)
    else $error("cell evaluated with tests in flight");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    int'(nres) <= MAX_RESULTS)
    else $error("result count beyond cap");

  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !store_wr)
    else $error("memory written during scan");

endmodule
